// ===== hdl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hdl/tbpc_pkg.sv =====
`default_nettype none

package tbpc_pkg;

    localparam logic [2:0] CLS_IDLE         = 3'd0;
    localparam logic [2:0] CLS_UNDECIDED    = 3'd1;
    localparam logic [2:0] CLS_UP_SHORT     = 3'd2;
    localparam logic [2:0] CLS_DOWN_SHORT   = 3'd3;
    localparam logic [2:0] CLS_BOTH         = 3'd4;
    localparam logic [2:0] CLS_UP_LONG      = 3'd5;
    localparam logic [2:0] CLS_DOWN_LONG    = 3'd6;
    localparam logic [2:0] CLS_WAIT_RELEASE = 3'd7;

    localparam logic REG_LONG_HOLD = 1'b0;
    localparam logic REG_SHORT_MIN = 1'b1;

    localparam logic [7:0] LONG_HOLD_RESET = 8'd10;
    localparam logic [7:0] SHORT_MIN_RESET = 8'd2;

    typedef struct packed {
        logic [7:0] long_hold_ticks;
        logic [7:0] short_min_ticks;
    } tbpc_cfg_t;

    function automatic logic [7:0] sat_inc(input logic [7:0] v);
        sat_inc = (v == 8'hFF) ? v : v + 8'd1;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/tbpc_cfg.sv =====
`default_nettype none

module tbpc_cfg (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic             cfg_index,
    input  wire logic [7:0]       cfg_data,
    output tbpc_pkg::tbpc_cfg_t   cfg
);

    logic [7:0] long_hold_reg;
    logic [7:0] short_min_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_hold_reg <= tbpc_pkg::LONG_HOLD_RESET;
            short_min_reg <= tbpc_pkg::SHORT_MIN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tbpc_pkg::REG_LONG_HOLD: long_hold_reg <= cfg_data;
                tbpc_pkg::REG_SHORT_MIN: short_min_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg.long_hold_ticks = long_hold_reg;
    assign cfg.short_min_ticks = short_min_reg;

endmodule

`default_nettype wire

// ===== hdl/tbpc_fsm.sv =====
`default_nettype none

module tbpc_fsm (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             step,
    input  wire logic             mode,
    input  wire logic             up_pin_level,
    input  wire logic             down_pin_level,
    input  wire tbpc_pkg::tbpc_cfg_t cfg,
    output logic [2:0]            class_state
);

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic [7:0] up_cnt_reg;
    logic [7:0] up_cnt_next;
    logic [7:0] down_cnt_reg;
    logic [7:0] down_cnt_next;

    logic       up;
    logic       down;
    logic [7:0] up_inc;
    logic [7:0] down_inc;

    assign up       = ~up_pin_level;
    assign down     = ~down_pin_level;
    assign up_inc   = tbpc_pkg::sat_inc(up_cnt_reg);
    assign down_inc = tbpc_pkg::sat_inc(down_cnt_reg);

    always_comb
    begin
        state_next    = state_reg;
        up_cnt_next   = up_cnt_reg;
        down_cnt_next = down_cnt_reg;
        if (mode)
        begin
            // read consumes a pending short or both event
            if (state_reg inside {tbpc_pkg::CLS_UP_SHORT, tbpc_pkg::CLS_DOWN_SHORT,
                                  tbpc_pkg::CLS_BOTH})
            begin
                state_next = tbpc_pkg::CLS_WAIT_RELEASE;
            end
        end
        else
        begin
            case (state_reg)
                tbpc_pkg::CLS_IDLE:
                begin
                    if (up && down)
                    begin
                        state_next = tbpc_pkg::CLS_BOTH;
                    end
                    else if (up)
                    begin
                        up_cnt_next = up_inc;
                        state_next  = tbpc_pkg::CLS_UNDECIDED;
                    end
                    else if (down)
                    begin
                        down_cnt_next = down_inc;
                        state_next    = tbpc_pkg::CLS_UNDECIDED;
                    end
                end
                tbpc_pkg::CLS_UNDECIDED:
                begin
                    if (up && down)
                    begin
                        state_next = tbpc_pkg::CLS_BOTH;
                    end
                    else if (up_cnt_reg != 8'd0)
                    begin
                        if (up)
                        begin
                            up_cnt_next = up_inc;
                            if (up_inc >= cfg.long_hold_ticks)
                                state_next = tbpc_pkg::CLS_UP_LONG;
                        end
                        else if (up_cnt_reg >= cfg.short_min_ticks)
                            state_next = tbpc_pkg::CLS_UP_SHORT;
                        else
                            state_next = tbpc_pkg::CLS_WAIT_RELEASE;
                    end
                    else if (down_cnt_reg != 8'd0)
                    begin
                        if (down)
                        begin
                            down_cnt_next = down_inc;
                            if (down_inc >= cfg.long_hold_ticks)
                                state_next = tbpc_pkg::CLS_DOWN_LONG;
                        end
                        else if (down_cnt_reg >= cfg.short_min_ticks)
                            state_next = tbpc_pkg::CLS_DOWN_SHORT;
                        else
                            state_next = tbpc_pkg::CLS_WAIT_RELEASE;
                    end
                end
                tbpc_pkg::CLS_UP_LONG:
                begin
                    if (!up)
                        state_next = tbpc_pkg::CLS_WAIT_RELEASE;
                end
                tbpc_pkg::CLS_DOWN_LONG:
                begin
                    if (!down)
                        state_next = tbpc_pkg::CLS_WAIT_RELEASE;
                end
                tbpc_pkg::CLS_WAIT_RELEASE:
                begin
                    if (!up && !down)
                    begin
                        up_cnt_next   = 8'd0;
                        down_cnt_next = 8'd0;
                        state_next    = tbpc_pkg::CLS_IDLE;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= tbpc_pkg::CLS_IDLE;
            up_cnt_reg   <= 8'd0;
            down_cnt_reg <= 8'd0;
        end
        else if (step)
        begin
            state_reg    <= state_next;
            up_cnt_reg   <= up_cnt_next;
            down_cnt_reg <= down_cnt_next;
        end
    end

    assign class_state = state_reg;

endmodule

`default_nettype wire

// ===== hdl/two_button_press_classifier.sv =====
// Path: an accepted item passes the input register, then the result register,
// where out_valid rises; out_stall can hold the item in the input register.
// Throughput: one item per cycle while out_stall is low; input and result
// registers let a new item enter while a finished result waits on out_stall.
// Reset (rst_n low, asynchronous): class idle, hold counters zero,
// long_hold_ticks 10, short_min_ticks 2, both channels empty.
`default_nettype none
`include "assert_macros.svh"

module two_button_press_classifier (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic       cfg_index,
    input  wire logic [7:0] cfg_data,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic       mode,
    input  wire logic       up_pin_level,
    input  wire logic       down_pin_level,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [2:0]      press_class
);

    tbpc_pkg::tbpc_cfg_t cfg;

    logic       stage_v_reg;
    logic       stage_v_next;
    logic       mode_reg;
    logic       up_pin_reg;
    logic       down_pin_reg;
    logic       out_v_reg;
    logic       out_v_next;
    logic [2:0] press_class_reg;
    logic [2:0] class_state;
    logic       in_xfer;
    logic       advance;

    tbpc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // staged item moves into the result register when that slot frees up
    assign advance  = stage_v_reg & (~out_v_reg | ~out_stall);
    assign in_stall = stage_v_reg & ~advance;
    assign in_xfer  = in_valid & ~in_stall;

    tbpc_fsm u_fsm (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (advance),
        .mode           (mode_reg),
        .up_pin_level   (up_pin_reg),
        .down_pin_level (down_pin_reg),
        .cfg            (cfg),
        .class_state    (class_state)
    );

    assign stage_v_next = in_xfer | (stage_v_reg & ~advance);
    assign out_v_next   = advance | (out_v_reg & out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_v_reg <= 1'b0;
            out_v_reg   <= 1'b0;
        end
        else
        begin
            stage_v_reg <= stage_v_next;
            out_v_reg   <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            mode_reg     <= mode;
            up_pin_reg   <= up_pin_level;
            down_pin_reg <= down_pin_level;
        end
        // result is the class as it stood before the item
        if (advance)
            press_class_reg <= class_state;
    end

    assign out_valid   = out_v_reg;
    assign press_class = press_class_reg;

    `ASSERT_SAME(a_stall_needs_item, in_stall, stage_v_reg)
    `ASSERT_NEXT(a_wait_exits_to_idle, class_state == tbpc_pkg::CLS_WAIT_RELEASE,
        class_state == tbpc_pkg::CLS_WAIT_RELEASE || class_state == tbpc_pkg::CLS_IDLE)
    `ASSERT_NEXT(a_read_consumes_both,
        advance && mode_reg && class_state == tbpc_pkg::CLS_BOTH,
        class_state == tbpc_pkg::CLS_WAIT_RELEASE)
    `ASSERT_NEXT(a_advance_fills_out, advance, out_v_reg)

endmodule

`default_nettype wire

// ===== sim/tb_two_button_press_classifier.sv =====
`timescale 1ns / 1ps

module tb_two_button_press_classifier;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 6;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int REPORT_LIMIT = 10;
    localparam int SETTLE_TICKS = 8;
    localparam int PHASES       = 9;
    localparam int DIRECTED_ROWS = 24;

    localparam logic MODE_TICK    = 1'b0;
    localparam logic MODE_READ    = 1'b1;
    localparam logic PIN_PRESSED  = 1'b0;
    localparam logic PIN_RELEASED = 1'b1;

    typedef struct packed {
        logic       mode;
        logic       up_lvl;
        logic       down_lvl;
        logic [8:0] reps;
        logic       typed;
        logic [2:0] want;
    } stim_row_t;

    typedef struct packed {
        logic [7:0] long_ticks;
        logic [7:0] short_ticks;
        logic       calm;
        int         budget;
    } phase_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic       cfg_index;
    logic [7:0] cfg_data;
    logic       in_valid;
    logic       in_stall;
    logic       mode;
    logic       up_pin_level;
    logic       down_pin_level;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [2:0] press_class;

    two_button_press_classifier u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mode           (mode),
        .up_pin_level   (up_pin_level),
        .down_pin_level (down_pin_level),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .press_class    (press_class)
    );

    // directed walk at the reset thresholds (long 10, short 2)
    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{MODE_TICK, PIN_RELEASED, PIN_RELEASED, 9'd1,  1'b1, tbpc_pkg::CLS_IDLE},
        '{MODE_READ, PIN_PRESSED,  PIN_PRESSED,  9'd1,  1'b1, tbpc_pkg::CLS_IDLE},
        '{MODE_TICK, PIN_PRESSED,  PIN_RELEASED, 9'd1,  1'b1, tbpc_pkg::CLS_IDLE},
        '{MODE_TICK, PIN_PRESSED,  PIN_RELEASED, 9'd1,  1'b0, tbpc_pkg::CLS_IDLE},
        '{MODE_TICK, PIN_RELEASED, PIN_RELEASED, 9'd1,  1'b0, tbpc_pkg::CLS_IDLE},
        '{MODE_READ, PIN_PRESSED,  PIN_RELEASED, 9'd1,  1'b0, tbpc_pkg::CLS_IDLE},
        '{MODE_TICK, PIN_RELEASED, PIN_RELEASED, 9'd1,  1'b0, tbpc_pkg::CLS_IDLE},
        // down bounce: released after one tick
        '{MODE_TICK, PIN_RELEASED, PIN_PRESSED,  9'd1,  1'b0, tbpc_pkg::CLS_IDLE},
        '{MODE_TICK, PIN_RELEASED, PIN_RELEASED, 9'd1,  1'b0, tbpc_pkg::CLS_IDLE},
        '{MODE_TICK, PIN_PRESSED,  PIN_PRESSED,  9'd1,  1'b0, tbpc_pkg::CLS_IDLE},
        '{MODE_TICK, PIN_RELEASED, PIN_RELEASED, 9'd1,  1'b0, tbpc_pkg::CLS_IDLE},
        '{MODE_TICK, PIN_PRESSED,  PIN_PRESSED,  9'd1,  1'b0, tbpc_pkg::CLS_IDLE},
        '{MODE_READ, PIN_RELEASED, PIN_RELEASED, 9'd1,  1'b0, tbpc_pkg::CLS_IDLE},
        '{MODE_TICK, PIN_RELEASED, PIN_RELEASED, 9'd1,  1'b0, tbpc_pkg::CLS_IDLE},
        // up held, then only down: up is judged, down ignored
        '{MODE_TICK, PIN_PRESSED,  PIN_RELEASED, 9'd2,  1'b0, tbpc_pkg::CLS_IDLE},
        '{MODE_TICK, PIN_RELEASED, PIN_PRESSED,  9'd1,  1'b0, tbpc_pkg::CLS_IDLE},
        '{MODE_TICK, PIN_PRESSED,  PIN_PRESSED,  9'd1,  1'b0, tbpc_pkg::CLS_IDLE},
        '{MODE_READ, PIN_RELEASED, PIN_PRESSED,  9'd1,  1'b0, tbpc_pkg::CLS_IDLE},
        '{MODE_TICK, PIN_RELEASED, PIN_RELEASED, 9'd1,  1'b0, tbpc_pkg::CLS_IDLE},
        '{MODE_TICK, PIN_PRESSED,  PIN_RELEASED, 9'd10, 1'b0, tbpc_pkg::CLS_IDLE},
        '{MODE_READ, PIN_PRESSED,  PIN_PRESSED,  9'd1,  1'b0, tbpc_pkg::CLS_IDLE},
        '{MODE_TICK, PIN_PRESSED,  PIN_RELEASED, 9'd1,  1'b0, tbpc_pkg::CLS_IDLE},
        '{MODE_TICK, PIN_RELEASED, PIN_PRESSED,  9'd1,  1'b0, tbpc_pkg::CLS_IDLE},
        '{MODE_TICK, PIN_RELEASED, PIN_RELEASED, 9'd1,  1'b0, tbpc_pkg::CLS_IDLE}
    };

    phase_t phase_plan [PHASES] = '{
        '{8'd10,  8'd2,   1'b0, 100},
        '{8'd2,   8'd1,   1'b1, 100},
        '{8'd0,   8'd0,   1'b0, 100},
        '{8'd1,   8'd0,   1'b0, 100},
        '{8'd255, 8'd255, 1'b0, 150},
        '{8'd3,   8'd255, 1'b1, 50},
        '{8'd6,   8'd1,   1'b0, 100},
        '{8'd20,  8'd3,   1'b0, 100},
        '{8'd4,   8'd4,   1'b0, 100}
    };

    // classifier shadow
    logic [2:0] model_class;
    logic [7:0] model_up_cnt;
    logic [7:0] model_dn_cnt;
    logic [7:0] model_long;
    logic [7:0] model_short;

    logic [2:0] class_due_q [$];
    logic [2:0] due_class;
    int         fault_count = 0;
    int         items_sent = 0;
    int         cycle_count = 0;
    int         stall_left = 0;
    bit         calm_phase = 1'b0;

    function automatic logic [7:0] bump(input logic [7:0] v);
        return (v == 8'hFF) ? v : v + 8'd1;
    endfunction

    // advances one hold counter while held and may update the class; returns the new count
    function automatic logic [7:0] judge_hold(input logic [7:0] cnt, input logic held,
                                              input logic [2:0] short_cls,
                                              input logic [2:0] long_cls);
        logic [7:0] n;
        n = cnt;
        if (held)
        begin
            n = bump(cnt);
            if (n >= model_long)
                model_class = long_cls;
        end
        else if (cnt >= model_short)
            model_class = short_cls;
        else
            model_class = tbpc_pkg::CLS_WAIT_RELEASE;
        return n;
    endfunction

    // returns the class as it stood before the item, then applies the item
    function automatic logic [2:0] classify_item(input logic rd, input logic u_lvl,
                                                 input logic d_lvl);
        logic [2:0] prior;
        logic       up_held;
        logic       dn_held;
        prior   = model_class;
        up_held = (u_lvl == PIN_PRESSED);
        dn_held = (d_lvl == PIN_PRESSED);
        if (rd == MODE_READ)
        begin
            if (model_class == tbpc_pkg::CLS_UP_SHORT ||
                model_class == tbpc_pkg::CLS_DOWN_SHORT ||
                model_class == tbpc_pkg::CLS_BOTH)
                model_class = tbpc_pkg::CLS_WAIT_RELEASE;
        end
        else
        begin
            case (model_class)
                tbpc_pkg::CLS_IDLE:
                begin
                    if (up_held && dn_held)
                        model_class = tbpc_pkg::CLS_BOTH;
                    else if (up_held)
                    begin
                        model_up_cnt = bump(model_up_cnt);
                        model_class  = tbpc_pkg::CLS_UNDECIDED;
                    end
                    else if (dn_held)
                    begin
                        model_dn_cnt = bump(model_dn_cnt);
                        model_class  = tbpc_pkg::CLS_UNDECIDED;
                    end
                end
                tbpc_pkg::CLS_UNDECIDED:
                begin
                    if (up_held && dn_held)
                        model_class = tbpc_pkg::CLS_BOTH;
                    else if (model_up_cnt != 8'd0)
                        model_up_cnt = judge_hold(model_up_cnt, up_held,
                                                  tbpc_pkg::CLS_UP_SHORT,
                                                  tbpc_pkg::CLS_UP_LONG);
                    else if (model_dn_cnt != 8'd0)
                        model_dn_cnt = judge_hold(model_dn_cnt, dn_held,
                                                  tbpc_pkg::CLS_DOWN_SHORT,
                                                  tbpc_pkg::CLS_DOWN_LONG);
                end
                tbpc_pkg::CLS_UP_LONG:
                begin
                    if (!up_held)
                        model_class = tbpc_pkg::CLS_WAIT_RELEASE;
                end
                tbpc_pkg::CLS_DOWN_LONG:
                begin
                    if (!dn_held)
                        model_class = tbpc_pkg::CLS_WAIT_RELEASE;
                end
                tbpc_pkg::CLS_WAIT_RELEASE:
                begin
                    if (!up_held && !dn_held)
                    begin
                        model_up_cnt = 8'd0;
                        model_dn_cnt = 8'd0;
                        model_class  = tbpc_pkg::CLS_IDLE;
                    end
                end
                default:
                begin
                end
            endcase
        end
        return prior;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm_phase || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    task automatic send_item(input logic m, input logic u_lvl, input logic d_lvl,
                             input logic typed, input logic [2:0] want);
        int         gap;
        logic [2:0] predicted;
        gap = pick_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        mode           <= m;
        up_pin_level   <= u_lvl;
        down_pin_level <= d_lvl;
        in_valid       <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        predicted = classify_item(m, u_lvl, d_lvl);
        class_due_q.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    task automatic wait_drained();
        while (class_due_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    task automatic settle_and_configure(input logic [7:0] long_ticks,
                                        input logic [7:0] short_ticks);
        in_valid <= 1'b0;
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= tbpc_pkg::REG_LONG_HOLD;
        cfg_data  <= long_ticks;
        @(posedge clk);
        cfg_index <= tbpc_pkg::REG_SHORT_MIN;
        cfg_data  <= short_ticks;
        @(posedge clk);
        cfg_we      <= 1'b0;
        model_long  = long_ticks;
        model_short = short_ticks;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #(CLK_HALF) clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver hold-off
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else
        begin
            out_stall <= 1'b0;
            if ($urandom_range(0, 2) == 0)
                stall_left <= pick_gap();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (class_due_q.size() == 0)
            begin
                fault_count++;
                if (fault_count <= REPORT_LIMIT)
                    $display("press_class %0d transferred with nothing expected",
                             press_class);
            end
            else
            begin
                due_class = class_due_q.pop_front();
                if (press_class !== due_class)
                begin
                    fault_count++;
                    if (fault_count <= REPORT_LIMIT)
                        $display("press_class mismatch: expected %0d, got %0d",
                                 due_class, press_class);
                end
            end
        end
    end

    initial
    begin
        int        p;
        int        i;
        int        hold;
        int        kind;
        int        phase_start;
        int        lng;
        int        sht;
        logic      u_lvl;
        logic      d_lvl;
        phase_t    plan;
        stim_row_t row;

        rst_n          <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_index      <= tbpc_pkg::REG_LONG_HOLD;
        cfg_data       <= 8'd0;
        in_valid       <= 1'b0;
        mode           <= MODE_TICK;
        up_pin_level   <= PIN_RELEASED;
        down_pin_level <= PIN_RELEASED;
        model_class  = tbpc_pkg::CLS_IDLE;
        model_up_cnt = 8'd0;
        model_dn_cnt = 8'd0;
        model_long   = tbpc_pkg::LONG_HOLD_RESET;
        model_short  = tbpc_pkg::SHORT_MIN_RESET;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < DIRECTED_ROWS; i++)
        begin
            row = directed_rows[i];
            repeat (row.reps)
                send_item(row.mode, row.up_lvl, row.down_lvl, row.typed, row.want);
        end

        for (p = 0; p < PHASES; p++)
        begin
            plan = phase_plan[p];
            settle_and_configure(plan.long_ticks, plan.short_ticks);
            calm_phase  = plan.calm;
            phase_start = items_sent;
            lng = int'(model_long);
            sht = int'(model_short);
            while (items_sent - phase_start < plan.budget)
            begin
                kind = $urandom_range(0, 19);
                if (kind < 3)
                begin
                    // noise
                    repeat ($urandom_range(1, 4))
                        send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                  1'($urandom_range(0, 1)), 1'b0, tbpc_pkg::CLS_IDLE);
                end
                else
                begin
                    if (kind < 9)
                    begin
                        u_lvl = PIN_PRESSED;
                        d_lvl = PIN_RELEASED;
                    end
                    else if (kind < 16)
                    begin
                        u_lvl = PIN_RELEASED;
                        d_lvl = PIN_PRESSED;
                    end
                    else
                    begin
                        u_lvl = PIN_PRESSED;
                        d_lvl = PIN_PRESSED;
                    end
                    // hold lengths cluster around both thresholds
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3: hold = $urandom_range(0, sht + 1);
                        4, 5, 6:    hold = lng - 1 + $urandom_range(0, 3);
                        7, 8:       hold = $urandom_range(1, 12);
                        default:    hold = $urandom_range(1, lng + 4);
                    endcase
                    if (hold < 1)
                        hold = 1;
                    for (i = 0; i < hold; i++)
                    begin
                        if ($urandom_range(0, 11) == 0)
                            send_item(MODE_READ, 1'($urandom_range(0, 1)),
                                      1'($urandom_range(0, 1)), 1'b0,
                                      tbpc_pkg::CLS_IDLE);
                        send_item(MODE_TICK, u_lvl, d_lvl, 1'b0, tbpc_pkg::CLS_IDLE);
                    end
                    if (u_lvl != d_lvl && $urandom_range(0, 6) == 0)
                        send_item(MODE_TICK, d_lvl, u_lvl, 1'b0, tbpc_pkg::CLS_IDLE);
                    send_item(MODE_TICK, PIN_RELEASED, PIN_RELEASED, 1'b0,
                              tbpc_pkg::CLS_IDLE);
                    if ($urandom_range(0, 1) == 1)
                        send_item(MODE_READ, 1'($urandom_range(0, 1)),
                                  1'($urandom_range(0, 1)), 1'b0, tbpc_pkg::CLS_IDLE);
                    repeat ($urandom_range(0, 2))
                        send_item(MODE_TICK, PIN_RELEASED, PIN_RELEASED, 1'b0,
                                  tbpc_pkg::CLS_IDLE);
                end
            end
        end

        in_valid <= 1'b0;
        wait_drained();
        if (fault_count == 0 && class_due_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
